@@ src/violated_group_selector_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the violated group selector core
// Two property forms shared by the assertion section of the core.
// ----------------------------------------------------------------------------
`ifndef VIOLATED_GROUP_SELECTOR_CORE_ASSERT_SVH
`define VIOLATED_GROUP_SELECTOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define VGS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define VGS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/vgs_pkg.sv @@
// ----------------------------------------------------------------------------
// Violated group selector package
// Rule codes, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package vgs_pkg;

	// Limits of the group and index space
	localparam int MAX_GROUP_LEN = 64;
	localparam int NUM_SETS      = 64;
	localparam int MAX_ENTRIES   = 65536;

	// Fixed point: 1.0 = 65536
	localparam logic [16:0] ONE_FIX  = 17'd65536;
	localparam logic [16:0] HALF_FIX = 17'd32768;

	// Reset values of the registers
	localparam logic [7:0]  TOL_RESET    = 8'd1;
	localparam logic [15:0] WINDOW_RESET = 16'd328;

	// Selection rules
	typedef enum logic [2:0] {
		RULE_FIRST     = 3'd0,
		RULE_NEAR_HALF = 3'd1,
		RULE_FREE      = 3'd2,
		RULE_MIN_SUM   = 3'd3,
		RULE_FREE_SUM  = 3'd4
	} rule_t;

	// Register indexes on the configuration channel
	typedef enum logic [1:0] {
		CFG_RULE   = 2'd0,
		CFG_TOL    = 2'd1,
		CFG_WINDOW = 2'd2
	} cfg_idx_t;

endpackage

@@ src/violated_group_selector_core.sv @@
// ----------------------------------------------------------------------------
// Violated group selector core
// Accumulates group statistics over a member stream and picks one group per pass.
// ----------------------------------------------------------------------------
// The block takes one member value per cycle and gives one result per pass, on
// the cycle after the pass-end member leaves the input register. Every member
// goes through an input register, then through one stage of logic that adds it
// to the open group (while it holds fewer than 64 members), checks the group
// against the tolerance window when the group or pass ends (one 8x7 multiply
// and two compares) and updates the best group of the pass under the selected
// rule; a pass-end member then loads the result register. The input side
// stalls only when a pass-end member meets a result that is still waiting on
// the output side. Register writes take effect for the next member processed.
module violated_group_selector_core (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // value[16:0], set_index[22:17], entry_index[38:23], pad
	input  logic [1:0]  s_tuser,   // is_fixed[0], group_end[1]
	input  logic        s_tlast,   // pass_end
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // best_set[5:0], best_entry[21:6], pad
	output logic [0:0]  m_tuser,   // found[0]
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	// Configuration registers
	vgs_pkg::rule_t rule_q;
	logic [7:0]     tol_q;
	logic [15:0]    window_q;

	// Input stage
	logic        valid_s1;
	logic [16:0] value_s1;
	logic        fixed_s1;
	logic [5:0]  set_s1;
	logic [15:0] entry_s1;
	logic        gend_s1;
	logic        pend_s1;

	// Open group
	logic [22:0] group_sum_q;
	logic [6:0]  group_len_q;
	logic [6:0]  group_nh_q;
	logic [6:0]  group_fixed_q;

	// Pass state
	logic        have_best_q;
	logic [5:0]  chosen_set_q;
	logic [15:0] chosen_entry_q;
	logic [6:0]  best_nh_q;
	logic [6:0]  best_free_q;
	logic [16:0] best_sum_q;

	// Result register
	logic        out_valid_q;
	logic        found_q;
	logic [5:0]  out_set_q;
	logic [15:0] out_entry_q;

	// Combinational
	logic        advance;
	logic        s_xfer;
	logic [16:0] v_sat;
	logic        room;
	logic        near;
	logic [22:0] sum_n;
	logic [6:0]  len_n;
	logic [6:0]  nh_n;
	logic [6:0]  fixed_n;
	logic [6:0]  free_n;
	logic [14:0] tol_len;
	logic        closing;
	logic        qualify;
	logic        in_range;
	logic        take;
	logic        have_best_n;
	logic [5:0]  chosen_set_n;
	logic [15:0] chosen_entry_n;
	logic [6:0]  best_nh_n;
	logic [6:0]  best_free_n;
	logic [16:0] best_sum_n;

	// Handshake: the stage stalls only when a result is due and the output is full
	assign advance   = valid_s1 && !(pend_s1 && out_valid_q && !m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign s_xfer    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_entry_q, out_set_q};
	assign m_tuser  = found_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= vgs_pkg::RULE_FIRST;
			tol_q    <= vgs_pkg::TOL_RESET;
			window_q <= vgs_pkg::WINDOW_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vgs_pkg::cfg_idx_t'(cfg_index))
				vgs_pkg::CFG_RULE:   rule_q   <= vgs_pkg::rule_t'(cfg_data[2:0]);
				vgs_pkg::CFG_TOL:    tol_q    <= cfg_data[7:0];
				vgs_pkg::CFG_WINDOW: window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register: payload
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			value_s1 <= s_tdata[16:0];
			set_s1   <= s_tdata[22:17];
			entry_s1 <= s_tdata[38:23];
			fixed_s1 <= s_tuser[0];
			gend_s1  <= s_tuser[1];
			pend_s1  <= s_tlast;
		end
	end

	// Member accumulation, group check and rule selection
	always_comb begin
		v_sat   = (value_s1 > vgs_pkg::ONE_FIX) ? vgs_pkg::ONE_FIX : value_s1;
		room    = group_len_q < 7'(vgs_pkg::MAX_GROUP_LEN);
		// half - w < v < half + w
		near    = (18'(v_sat) + 18'(window_q) > 18'(vgs_pkg::HALF_FIX)) &&
		          (18'(v_sat) < 18'(vgs_pkg::HALF_FIX) + 18'(window_q));
		sum_n   = room ? group_sum_q + 23'(v_sat) : group_sum_q;
		len_n   = room ? group_len_q + 7'd1 : group_len_q;
		nh_n    = (room && near) ? group_nh_q + 7'd1 : group_nh_q;
		fixed_n = (room && fixed_s1) ? group_fixed_q + 7'd1 : group_fixed_q;
		free_n  = len_n - fixed_n;
		closing = gend_s1 || pend_s1;

		// tol*len < sum < 1.0 - tol*len
		tol_len  = 15'(tol_q) * 15'(len_n);
		qualify  = (sum_n > 23'(tol_len)) &&
		           (24'(sum_n) + 24'(tol_len) < 24'(vgs_pkg::ONE_FIX));
		in_range = (32'(set_s1) < vgs_pkg::NUM_SETS) &&
		           (32'(entry_s1) < vgs_pkg::MAX_ENTRIES);

		unique case (rule_q)
			vgs_pkg::RULE_FIRST:     take = !have_best_q;
			vgs_pkg::RULE_NEAR_HALF: take = nh_n > best_nh_q;
			vgs_pkg::RULE_FREE:      take = free_n > best_free_q;
			vgs_pkg::RULE_MIN_SUM:   take = sum_n < 23'(best_sum_q);
			vgs_pkg::RULE_FREE_SUM:  take = (free_n > best_free_q) ||
			                                ((free_n == best_free_q) &&
			                                 (sum_n < 23'(best_sum_q)));
			default:                 take = 1'b0;
		endcase
		take = take && closing && qualify && in_range;

		have_best_n    = have_best_q;
		chosen_set_n   = chosen_set_q;
		chosen_entry_n = chosen_entry_q;
		best_nh_n      = best_nh_q;
		best_free_n    = best_free_q;
		best_sum_n     = best_sum_q;
		if (take) begin
			have_best_n    = 1'b1;
			chosen_set_n   = set_s1;
			chosen_entry_n = entry_s1;
			if (rule_q == vgs_pkg::RULE_NEAR_HALF) begin
				best_nh_n = nh_n;
			end
			if (rule_q == vgs_pkg::RULE_FREE || rule_q == vgs_pkg::RULE_FREE_SUM) begin
				best_free_n = free_n;
			end
			if (rule_q == vgs_pkg::RULE_MIN_SUM || rule_q == vgs_pkg::RULE_FREE_SUM) begin
				best_sum_n = sum_n[16:0];
			end
		end
	end

	// Group and pass state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_sum_q    <= '0;
			group_len_q    <= '0;
			group_nh_q     <= '0;
			group_fixed_q  <= '0;
			have_best_q    <= 1'b0;
			chosen_set_q   <= '0;
			chosen_entry_q <= '0;
			best_nh_q      <= '0;
			best_free_q    <= '0;
			best_sum_q     <= vgs_pkg::ONE_FIX;
		end else if (advance) begin
			if (closing) begin
				group_sum_q   <= '0;
				group_len_q   <= '0;
				group_nh_q    <= '0;
				group_fixed_q <= '0;
			end else begin
				group_sum_q   <= sum_n;
				group_len_q   <= len_n;
				group_nh_q    <= nh_n;
				group_fixed_q <= fixed_n;
			end
			if (pend_s1) begin
				have_best_q    <= 1'b0;
				chosen_set_q   <= '0;
				chosen_entry_q <= '0;
				best_nh_q      <= '0;
				best_free_q    <= '0;
				best_sum_q     <= vgs_pkg::ONE_FIX;
			end else begin
				have_best_q    <= have_best_n;
				chosen_set_q   <= chosen_set_n;
				chosen_entry_q <= chosen_entry_n;
				best_nh_q      <= best_nh_n;
				best_free_q    <= best_free_n;
				best_sum_q     <= best_sum_n;
			end
		end
	end

	// Result register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && pend_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result register: payload, zero when nothing was chosen
	always_ff @(posedge clk) begin
		if (advance && pend_s1) begin
			found_q     <= have_best_n;
			out_set_q   <= have_best_n ? chosen_set_n : '0;
			out_entry_q <= have_best_n ? chosen_entry_n : '0;
		end
	end

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
`include "violated_group_selector_core_assert.svh"

	`VGS_ASSERT_NOW(a_result_from_pass_end, $rose(out_valid_q), $past(valid_s1 && pend_s1), "result without pass end")
	`VGS_ASSERT_NOW(a_empty_result_zero, out_valid_q && !found_q, out_set_q == '0 && out_entry_q == '0, "empty result carries an index")
	`VGS_ASSERT_NEXT(a_stall_holds_item, valid_s1 && !advance, valid_s1, "stalled item dropped")
	`VGS_ASSERT_NEXT(a_group_cleared, advance && closing, group_len_q == '0 && group_sum_q == '0, "group not cleared at close")
	`VGS_ASSERT_NEXT(a_pass_cleared, advance && pend_s1, !have_best_q && best_sum_q == vgs_pkg::ONE_FIX, "pass not cleared after result")

endmodule
